FILE: rtl/svbft_pkg.sv
// Shared types, constants and helpers for the servo bus frame transceiver.
package svbft_pkg;

    // Frame constants
    localparam logic [7:0] SYNC_BYTE       = 8'hFF;
    localparam logic [4:0] MAX_PARAMS      = 5'd26;
    localparam logic [7:0] GUARD_RESET     = 8'd5;
    localparam logic [7:0] WR_OPCODE_RESET = 8'd3;
    localparam int         MAX_RESULTS     = 6;
    localparam int         CNT_W           = $clog2(MAX_RESULTS + 1);
    localparam int         PTR_W           = $clog2(MAX_RESULTS);

    // Configuration register indexes
    localparam logic CFG_GUARD_LIMIT = 1'b0;
    localparam logic CFG_WRITE_OP    = 1'b1;

    // Input item modes
    typedef enum logic [1:0] {
        MODE_TX_START = 2'd0,
        MODE_TX_PARAM = 2'd1,
        MODE_RX_BYTE  = 2'd2,
        MODE_RX_TOUT  = 2'd3
    } mode_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_TX_BYTE  = 3'd0,
        KIND_RX_BYTE  = 3'd1,
        KIND_RX_DONE  = 3'd2,
        KIND_TX_REJ   = 3'd3,
        KIND_RX_TOUT  = 3'd4
    } kind_t;

    // One result item
    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic [8:0] byte_index;
        logic [5:0] frame_length;
        logic       checksum_error;
        logic       last;
    } result_t;

    // All results caused by one input item
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic    [CNT_W-1:0]       cnt;
    } group_t;

    function automatic result_t mk_res(kind_t k, logic [7:0] b, logic [8:0] idx,
                                       logic [5:0] flen, logic err, logic lst);
        result_t r;
        r.kind           = k;
        r.out_byte       = b;
        r.byte_index     = idx;
        r.frame_length   = flen;
        r.checksum_error = err;
        r.last           = lst;
        return r;
    endfunction

endpackage

FILE: rtl/svbft_tx.sv
// Transmit framer: header, parameter echo and checksum generation.
module svbft_tx (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   apply,
    input  svbft_pkg::mode_t       mode,
    input  logic [7:0]             data_byte,
    input  logic [7:0]             device_id,
    input  logic [7:0]             instruction,
    input  logic [4:0]             param_count,
    input  logic [7:0]             guard_limit,
    input  logic [7:0]             write_op,
    output svbft_pkg::group_t      grp
);
    import svbft_pkg::*;

    logic [7:0] tx_sum_reg, tx_sum_next;
    logic [4:0] tx_left_reg, tx_left_next;
    logic [5:0] tx_index_reg, tx_index_next;
    logic [5:0] tx_len_reg, tx_len_next;

    logic       reject;
    logic [4:0] cnt_sat;
    logic [5:0] len6;
    logic [7:0] hdr_sum;
    logic [7:0] par_sum;
    logic [4:0] left_dec;
    logic [5:0] idx_inc;

    // Group build and state update for start and parameter items
    always_comb
    begin
        reject   = (instruction == write_op) && (data_byte <= guard_limit);
        cnt_sat  = (param_count > MAX_PARAMS) ? MAX_PARAMS : param_count;
        len6     = {1'b0, cnt_sat} + 6'd6;
        hdr_sum  = device_id + {3'b0, cnt_sat} + 8'd2 + instruction;
        par_sum  = tx_sum_reg + data_byte;
        left_dec = tx_left_reg - 5'd1;
        idx_inc  = tx_index_reg + 6'd1;

        grp           = '0;
        tx_sum_next   = tx_sum_reg;
        tx_left_next  = tx_left_reg;
        tx_index_next = tx_index_reg;
        tx_len_next   = tx_len_reg;

        case (mode)
            MODE_TX_START:
            begin
                if (reject)
                begin
                    grp.res[0]    = mk_res(KIND_TX_REJ, 8'd0, 9'd0, 6'd0, 1'b0, 1'b1);
                    grp.cnt       = CNT_W'(1);
                    tx_sum_next   = '0;
                    tx_left_next  = '0;
                    tx_index_next = '0;
                    tx_len_next   = '0;
                end
                else
                begin
                    grp.res[0] = mk_res(KIND_TX_BYTE, SYNC_BYTE, 9'd0, len6, 1'b0, 1'b0);
                    grp.res[1] = mk_res(KIND_TX_BYTE, SYNC_BYTE, 9'd1, len6, 1'b0, 1'b0);
                    grp.res[2] = mk_res(KIND_TX_BYTE, device_id, 9'd2, len6, 1'b0, 1'b0);
                    grp.res[3] = mk_res(KIND_TX_BYTE, {3'b0, cnt_sat} + 8'd2, 9'd3, len6,
                                        1'b0, 1'b0);
                    grp.res[4] = mk_res(KIND_TX_BYTE, instruction, 9'd4, len6, 1'b0,
                                        cnt_sat != 5'd0);
                    tx_sum_next  = hdr_sum;
                    tx_left_next = cnt_sat;
                    if (cnt_sat == 5'd0)
                    begin
                        // empty parameter list: checksum closes the frame at once
                        grp.res[5]    = mk_res(KIND_TX_BYTE, ~hdr_sum, 9'd5, len6, 1'b0, 1'b1);
                        grp.cnt       = CNT_W'(6);
                        tx_index_next = 6'd6;
                        tx_len_next   = '0;
                    end
                    else
                    begin
                        grp.cnt       = CNT_W'(5);
                        tx_index_next = 6'd5;
                        tx_len_next   = len6;
                    end
                end
            end
            MODE_TX_PARAM:
            begin
                if (tx_left_reg != 5'd0)
                begin
                    tx_sum_next  = par_sum;
                    tx_left_next = left_dec;
                    grp.res[0]   = mk_res(KIND_TX_BYTE, data_byte, {3'b0, tx_index_reg},
                                          tx_len_reg, 1'b0, left_dec != 5'd0);
                    if (left_dec == 5'd0)
                    begin
                        grp.res[1]    = mk_res(KIND_TX_BYTE, ~par_sum, {3'b0, idx_inc},
                                               tx_len_reg, 1'b0, 1'b1);
                        grp.cnt       = CNT_W'(2);
                        tx_index_next = tx_index_reg + 6'd2;
                    end
                    else
                    begin
                        grp.cnt       = CNT_W'(1);
                        tx_index_next = idx_inc;
                    end
                end
            end
            default:
            begin
                grp = '0;
            end
        endcase
    end

    // Transmit state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_sum_reg   <= '0;
            tx_left_reg  <= '0;
            tx_index_reg <= '0;
            tx_len_reg   <= '0;
        end
        else if (apply)
        begin
            tx_sum_reg   <= tx_sum_next;
            tx_left_reg  <= tx_left_next;
            tx_index_reg <= tx_index_next;
            tx_len_reg   <= tx_len_next;
        end
    end

endmodule

FILE: rtl/svbft_rx.sv
// Receive checker: byte numbering, length capture and checksum compare.
module svbft_rx (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               apply,
    input  svbft_pkg::mode_t   mode,
    input  logic [7:0]         data_byte,
    output svbft_pkg::group_t  grp
);
    import svbft_pkg::*;

    logic [8:0] rx_index_reg, rx_index_next;
    logic [8:0] rx_expected_reg, rx_expected_next;
    logic [7:0] rx_sum_reg, rx_sum_next;

    logic [8:0] exp_cur;
    logic       done;
    logic [7:0] chk;

    // Group build and state update for received bytes and timeouts
    always_comb
    begin
        exp_cur = (rx_index_reg == 9'd3) ? (9'd4 + {1'b0, data_byte}) : rx_expected_reg;
        done    = (rx_index_reg >= 9'd3) && (exp_cur != 9'd0) &&
                  (({1'b0, rx_index_reg} + 10'd1) >= {1'b0, exp_cur});
        chk     = ~rx_sum_reg;

        grp              = '0;
        rx_index_next    = rx_index_reg;
        rx_expected_next = rx_expected_reg;
        rx_sum_next      = rx_sum_reg;

        case (mode)
            MODE_RX_BYTE:
            begin
                grp.res[0] = mk_res(KIND_RX_BYTE, data_byte, rx_index_reg, 6'd0, 1'b0, !done);
                if (done)
                begin
                    grp.res[1]       = mk_res(KIND_RX_DONE, chk, rx_index_reg, 6'd0,
                                              chk != data_byte, 1'b1);
                    grp.cnt          = CNT_W'(2);
                    rx_index_next    = '0;
                    rx_expected_next = '0;
                    rx_sum_next      = '0;
                end
                else
                begin
                    grp.cnt          = CNT_W'(1);
                    rx_expected_next = exp_cur;
                    if (rx_index_reg >= 9'd2)
                        rx_sum_next = rx_sum_reg + data_byte;
                    if (rx_index_reg != 9'h1FF)
                        rx_index_next = rx_index_reg + 9'd1;
                end
            end
            MODE_RX_TOUT:
            begin
                grp.res[0]       = mk_res(KIND_RX_TOUT, 8'd0, rx_index_reg, 6'd0, 1'b0, 1'b1);
                grp.cnt          = CNT_W'(1);
                rx_index_next    = '0;
                rx_expected_next = '0;
                rx_sum_next      = '0;
            end
            default:
            begin
                grp = '0;
            end
        endcase
    end

    // Receive state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_index_reg    <= '0;
            rx_expected_reg <= '0;
            rx_sum_reg      <= '0;
        end
        else if (apply)
        begin
            rx_index_reg    <= rx_index_next;
            rx_expected_reg <= rx_expected_next;
            rx_sum_reg      <= rx_sum_next;
        end
    end

endmodule

FILE: rtl/svbft_emit.sv
// Result register: holds one group of results and sends them one per transaction.
module svbft_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  svbft_pkg::group_t  grp,
    output logic               free,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [23:0]        m_axis_tdata,   // out_byte, byte_index, frame_length, checksum_error
    output logic [2:0]         m_axis_tuser,   // kind
    output logic               m_axis_tlast
);
    import svbft_pkg::*;

    group_t           grp_reg;
    logic [PTR_W-1:0] ptr_reg;
    logic             valid_reg;

    result_t          cur;
    logic             take;
    logic             at_end;

    // Output selection
    always_comb
    begin
        cur           = grp_reg.res[ptr_reg];
        take          = valid_reg && m_axis_tready;
        at_end        = (CNT_W'(ptr_reg) + CNT_W'(1)) == grp_reg.cnt;
        free          = !valid_reg || (take && at_end);
        m_axis_tvalid = valid_reg;
        m_axis_tdata  = {cur.checksum_error, cur.frame_length, cur.byte_index, cur.out_byte};
        m_axis_tuser  = cur.kind;
        m_axis_tlast  = cur.last;
    end

    // Group and pointer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ptr_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            ptr_reg   <= '0;
        end
        else if (take && at_end)
        begin
            valid_reg <= 1'b0;
            ptr_reg   <= '0;
        end
        else if (take)
        begin
            ptr_reg <= ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            grp_reg <= grp;
    end

`ifndef ASSERT_OFF
    // A loaded group is never empty
    a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> grp.cnt != '0)
        else $error("empty result group loaded");

    // Only load when the register is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result group overwritten");

    // Pointer stays inside the group
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (CNT_W'(ptr_reg) < grp_reg.cnt))
        else $error("result pointer out of range");

    // tlast marks exactly the final result of a group
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (m_axis_tlast == at_end))
        else $error("tlast does not match group end");

    // Final transaction without a new load empties the register
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (take && at_end && !load) |=> !valid_reg)
        else $error("result register did not drain");
`endif

endmodule

FILE: rtl/servo_bus_frame_transceiver_core.sv
// Top level of the servo bus frame transceiver: input register, framers, result register.
//
// Usage:
// - Input items arrive on s_axis (tuser = mode, tdata = data_byte, device_id,
//   instruction, param_count). A tx start emits the frame header (and the checksum when
//   the count is zero), or a reject result for a guarded write; each tx parameter is
//   echoed, and the last one is followed by the inverted checksum. Rx bytes are echoed, numbered
//   and the frame end is reported with a checksum check; an rx timeout ends reception.
// - Results leave on m_axis (tuser = kind); tlast marks the final result of an item.
// - The cfg channel writes guard_address_limit (index 0) or write_opcode (index 1);
//   it is always ready and should be used only while the block is idle.
// Timing:
// - An accepted item is registered in the input register, then turned into its whole
//   result group, which is loaded into the result register once that is free; its first
//   result is then on m_axis.
// - One item per cycle while each item yields at most one result and m_axis does not
//   stall; an item with n results occupies the result register for n output transactions.
// - When m_axis stalls, the result register holds and one more item waits in the
//   input register; s_axis_tready then drops.
// Reset: rst_n clears all frame state and restores the register reset values.
module servo_bus_frame_transceiver_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // data_byte, device_id, instruction, param_count, pad
    input  logic [1:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_byte, byte_index, frame_length, checksum_error
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import svbft_pkg::*;

    logic [7:0] guard_reg;
    logic [7:0] wr_op_reg;

    logic       in_valid_reg;
    mode_t      mode_reg;
    logic [7:0] data_reg;
    logic [7:0] id_reg;
    logic [7:0] instr_reg;
    logic [4:0] count_reg;

    group_t     tx_grp;
    group_t     rx_grp;
    group_t     sel_grp;
    logic       free;
    logic       advance;
    logic       is_tx;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && free;
    assign s_axis_tready = !in_valid_reg || advance;
    assign is_tx         = (mode_reg == MODE_TX_START) || (mode_reg == MODE_TX_PARAM);
    assign sel_grp       = is_tx ? tx_grp : rx_grp;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guard_reg <= GUARD_RESET;
            wr_op_reg <= WR_OPCODE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GUARD_LIMIT: guard_reg <= cfg_data;
                CFG_WRITE_OP:    wr_op_reg <= cfg_data;
                default:         guard_reg <= guard_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            mode_reg  <= mode_t'(s_axis_tuser);
            data_reg  <= s_axis_tdata[7:0];
            id_reg    <= s_axis_tdata[15:8];
            instr_reg <= s_axis_tdata[23:16];
            count_reg <= s_axis_tdata[28:24];
        end
    end

    svbft_tx u_tx (
        .clk         (clk),
        .rst_n       (rst_n),
        .apply       (advance && is_tx),
        .mode        (mode_reg),
        .data_byte   (data_reg),
        .device_id   (id_reg),
        .instruction (instr_reg),
        .param_count (count_reg),
        .guard_limit (guard_reg),
        .write_op    (wr_op_reg),
        .grp         (tx_grp)
    );

    svbft_rx u_rx (
        .clk       (clk),
        .rst_n     (rst_n),
        .apply     (advance && !is_tx),
        .mode      (mode_reg),
        .data_byte (data_reg),
        .grp       (rx_grp)
    );

    svbft_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && (sel_grp.cnt != '0)),
        .grp           (sel_grp),
        .free          (free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the servo bus frame transceiver core.
`timescale 1ns / 1ps

module tb;

    import svbft_pkg::*;

    localparam int DRAIN_CYCLES = 8;       // settle time after the last result
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int LIMIT        = 300000;  // watchdog, in clock cycles
    localparam int MAX_PRINTED  = 40;

    // Frame predictor and result store
    class frame_scoreboard;
        bit [7:0] guard_limit;
        bit [7:0] write_op;

        // transmit framer state
        bit [7:0] tx_sum;
        bit [4:0] tx_left;
        bit [8:0] tx_pos;
        bit [5:0] tx_len;

        // receive checker state
        bit [8:0] rx_pos;
        bit [8:0] rx_total;
        bit [7:0] rx_sum;

        result_t  grp[$];
        result_t  expected_q[$];

        int mismatches;
        int checked;
        int tx_frames;
        int refused;
        int rx_frames;
        int rx_bad;
        int timeouts;

        function new();
            guard_limit = GUARD_RESET;
            write_op    = WR_OPCODE_RESET;
            tx_sum      = '0;
            tx_left     = '0;
            tx_pos      = '0;
            tx_len      = '0;
            rx_pos      = '0;
            rx_total    = '0;
            rx_sum      = '0;
            mismatches  = 0;
            checked     = 0;
            tx_frames   = 0;
            refused     = 0;
            rx_frames   = 0;
            rx_bad      = 0;
            timeouts    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_reg(logic idx, bit [7:0] value);
            if (idx == CFG_GUARD_LIMIT)
                guard_limit = value;
            else
                write_op = value;
        endfunction

        function void add(kind_t k, bit [7:0] b, bit [8:0] idx, bit [5:0] flen, bit err);
            result_t r;
            r.kind           = k;
            r.out_byte       = b;
            r.byte_index     = idx;
            r.frame_length   = flen;
            r.checksum_error = err;
            r.last           = 1'b0;
            grp.push_back(r);
        endfunction

        function void tx_emit(bit [7:0] b);
            add(KIND_TX_BYTE, b, tx_pos, tx_len, 1'b0);
            if (tx_pos < 9'd511)
                tx_pos++;
        endfunction

        function void rx_clear();
            rx_pos   = '0;
            rx_total = '0;
            rx_sum   = '0;
        endfunction

        // Work out the results of one accepted input transaction
        function int note_input(mode_t m, bit [7:0] data, bit [7:0] id, bit [7:0] instr,
                                bit [4:0] count);
            bit [4:0] n_par;
            bit [8:0] idx;
            bit [7:0] chk;
            result_t  r;
            grp.delete();
            case (m)
                MODE_TX_START:
                begin
                    if (instr == write_op && data <= guard_limit)
                    begin
                        // guarded address: refuse and close any open frame
                        tx_left = '0;
                        tx_pos  = '0;
                        tx_len  = '0;
                        tx_sum  = '0;
                        add(KIND_TX_REJ, 8'h00, 9'd0, 6'd0, 1'b0);
                    end
                    else
                    begin
                        n_par   = (count > MAX_PARAMS) ? MAX_PARAMS : count;
                        tx_pos  = '0;
                        tx_len  = 6'(n_par) + 6'd6;
                        tx_left = n_par;
                        tx_sum  = id + 8'(n_par) + 8'd2 + instr;
                        tx_emit(SYNC_BYTE);
                        tx_emit(SYNC_BYTE);
                        tx_emit(id);
                        tx_emit(8'(n_par) + 8'd2);
                        tx_emit(instr);
                        // no parameters: checksum goes out right away
                        if (n_par == 0)
                        begin
                            tx_emit(~tx_sum);
                            tx_len = '0;
                        end
                    end
                end
                MODE_TX_PARAM:
                begin
                    if (tx_left != 0)
                    begin
                        tx_sum = tx_sum + data;
                        tx_emit(data);
                        tx_left--;
                        if (tx_left == 0)
                            tx_emit(~tx_sum);
                    end
                end
                MODE_RX_BYTE:
                begin
                    idx = rx_pos;
                    add(KIND_RX_BYTE, data, idx, 6'd0, 1'b0);
                    if (idx == 9'd3)
                        rx_total = 9'd4 + 9'(data);
                    if (idx >= 9'd3 && rx_total != 0 && 10'(idx) + 10'd1 >= 10'(rx_total))
                    begin
                        chk = ~rx_sum;
                        add(KIND_RX_DONE, chk, idx, 6'd0, chk != data);
                        rx_clear();
                    end
                    else
                    begin
                        if (idx >= 9'd2)
                            rx_sum = rx_sum + data;
                        if (rx_pos < 9'd511)
                            rx_pos++;
                    end
                end
                default:
                begin
                    add(KIND_RX_TOUT, 8'h00, rx_pos, 6'd0, 1'b0);
                    rx_clear();
                end
            endcase
            if (grp.size() != 0)
            begin
                r = grp.pop_back();
                r.last = 1'b1;
                grp.push_back(r);
                foreach (grp[i])
                    expected_q.push_back(grp[i]);
            end
            return grp.size();
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("ERROR @%0t: %s", $time, msg);
        endtask

        // Compare one output transaction with the oldest expectation
        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result kind=%0d byte=%02h idx=%0d",
                                 got.kind, got.out_byte, got.byte_index));
            end
            else
            begin
                want = expected_q.pop_front();
                checked++;
                if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                    got.byte_index !== want.byte_index ||
                    got.frame_length !== want.frame_length ||
                    got.checksum_error !== want.checksum_error || got.last !== want.last)
                begin
                    report($sformatf({"got kind=%0d byte=%02h idx=%0d len=%0d err=%b last=%b",
                                      " want kind=%0d byte=%02h idx=%0d len=%0d err=%b last=%b"},
                                     got.kind, got.out_byte, got.byte_index, got.frame_length,
                                     got.checksum_error, got.last, want.kind, want.out_byte,
                                     want.byte_index, want.frame_length, want.checksum_error,
                                     want.last));
                end
                case (want.kind)
                    KIND_TX_BYTE:
                        if (want.byte_index == 0)
                            tx_frames++;
                    KIND_TX_REJ:
                        refused++;
                    KIND_RX_DONE:
                    begin
                        rx_frames++;
                        if (want.checksum_error)
                            rx_bad++;
                    end
                    KIND_RX_TOUT:
                        timeouts++;
                    default:
                        ;
                endcase
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    frame_scoreboard sb = new();

    int burst_left  = 0;
    int useful_items = 0;
    int settings    = 1;
    bit hold_req    = 1'b0;

    servo_bus_frame_transceiver_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog
    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result('{kind: kind_t'(m_axis_tuser), out_byte: m_axis_tdata[7:0],
                              byte_index: m_axis_tdata[16:8],
                              frame_length: m_axis_tdata[22:17],
                              checksum_error: m_axis_tdata[23], last: m_axis_tlast});
    end

    // Receiver: changing stall patterns, plus a long hold-off on request
    initial
    begin
        int style;
        int left;
        m_axis_tready = 1'b0;
        style = 0;
        left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    style = $urandom_range(0, 3);
                    left  = $urandom_range(20, 120);
                end
                left--;
                case (style)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 9) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) < 2);
                endcase
            end
        end
    end

    // Offer one item; bursts with random gaps between them
    task automatic send_item(mode_t m, bit [7:0] data, bit [7:0] id, bit [7:0] instr,
                             bit [4:0] count);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= m;
        s_axis_tdata  <= {3'b000, count, instr, id, data};
        do @(posedge clk); while (!s_axis_tready);
        if (sb.note_input(m, data, id, instr, count) > 0)
            useful_items++;
    endtask

    task automatic send_rx(bit [7:0] b);
        send_item(MODE_RX_BYTE, b, 8'($urandom), 8'($urandom), 5'($urandom));
    endtask

    task automatic send_timeout();
        send_item(MODE_RX_TOUT, 8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
    endtask

    // Instruction frame: start, then its parameters (address first); cut drops the tail
    task automatic tx_frame(bit [7:0] id, bit [7:0] instr, bit [4:0] count, bit [7:0] addr,
                            bit cut);
        int n_par;
        send_item(MODE_TX_START, addr, id, instr, count);
        if (!(instr == sb.write_op && addr <= sb.guard_limit))
        begin
            n_par = (count > MAX_PARAMS) ? MAX_PARAMS : count;
            if (cut && n_par > 0)
                n_par = $urandom_range(0, n_par - 1);
            for (int i = 0; i < n_par; i++)
                send_item(MODE_TX_PARAM, (i == 0) ? addr : 8'($urandom), 8'($urandom),
                          8'($urandom), 5'($urandom));
        end
    endtask

    // Status frame on the receive side; a zero length makes byte 3 the checksum
    task automatic rx_frame(bit [7:0] id, bit [7:0] plen, bit corrupt, bit cut);
        bit [7:0] frame_bytes[$];
        bit [7:0] sum;
        bit [7:0] b;
        int       n_send;
        frame_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : SYNC_BYTE);
        frame_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : SYNC_BYTE);
        frame_bytes.push_back(id);
        frame_bytes.push_back(plen);
        sum = id + plen;
        if (plen != 0)
        begin
            for (int i = 0; i < plen - 1; i++)
            begin
                b   = 8'($urandom);
                sum = sum + b;
                frame_bytes.push_back(b);
            end
            b = ~sum;
            if (corrupt)
                b = b ^ 8'(1 << $urandom_range(0, 7));
            frame_bytes.push_back(b);
        end
        n_send = cut ? $urandom_range(1, frame_bytes.size() - 1) : frame_bytes.size();
        for (int i = 0; i < n_send; i++)
            send_rx(frame_bytes[i]);
        if (cut)
            send_timeout();
    endtask

    // Register writes, only once the block has gone quiet
    task automatic write_regs(bit [7:0] guard, bit [7:0] wop);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_GUARD_LIMIT;
        cfg_data  <= guard;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(CFG_GUARD_LIMIT, guard);
        cfg_index <= CFG_WRITE_OP;
        cfg_data  <= wop;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(CFG_WRITE_OP, wop);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Random mix: mostly well-formed frames, some broken ones and noise
    task automatic run_random(int n);
        int       stop_at;
        int       pick;
        bit [7:0] instr;
        bit [7:0] addr;
        bit [7:0] id;
        bit [7:0] plen;
        bit [4:0] count;
        stop_at = useful_items + n;
        while (useful_items < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                instr = ($urandom_range(0, 2) == 0) ? sb.write_op : 8'($urandom);
                case ($urandom_range(0, 3))
                    0:       addr = sb.guard_limit;
                    1:       addr = (sb.guard_limit == 8'hFF) ? 8'hFF : sb.guard_limit + 8'd1;
                    2:       addr = 8'h00;
                    default: addr = 8'($urandom);
                endcase
                count = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                    : 5'($urandom_range(0, 5));
                tx_frame(8'($urandom), instr, count, addr, $urandom_range(0, 7) == 0);
            end
            else if (pick < 85)
            begin
                plen = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(7, 30))
                                                    : 8'($urandom_range(0, 6));
                id   = (plen == 0 && $urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom);
                rx_frame(id, plen, $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
            end
            else
            begin
                // single item of any kind, fields fully random
                send_item(mode_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                          8'($urandom), 5'($urandom));
            end
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_TX_START;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_GUARD_LIMIT;
        cfg_data      = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: transmit side at reset register values
        send_item(MODE_TX_PARAM, 8'h5A, 8'h00, 8'h00, 5'd0);            // no open frame
        send_item(MODE_TX_START, 8'h00, 8'h00, 8'h00, 5'd0);            // count zero
        send_item(MODE_TX_START, 8'hFF, 8'hFF, 8'hFF, 5'd31);           // count saturates
        send_item(MODE_TX_PARAM, 8'hAA, 8'h00, 8'h00, 5'd0);
        send_item(MODE_TX_START, 8'h12, 8'h01, 8'h02, 5'd2);            // restart open frame
        send_item(MODE_TX_PARAM, 8'hFF, 8'h00, 8'h00, 5'd0);
        send_item(MODE_TX_PARAM, 8'h80, 8'h00, 8'h00, 5'd0);
        send_item(MODE_TX_START, 8'h06, 8'h07, WR_OPCODE_RESET, 5'd3);  // just above guard
        send_item(MODE_TX_PARAM, 8'h06, 8'h00, 8'h00, 5'd0);
        send_item(MODE_TX_START, 8'h05, 8'h07, WR_OPCODE_RESET, 5'd1);  // refused, closes
        send_item(MODE_TX_PARAM, 8'h33, 8'h00, 8'h00, 5'd0);            // ignored now

        // Directed: receive side
        rx_frame(8'hFF, 8'h00, 1'b0, 1'b0);     // zero length, good check
        rx_frame(8'h07, 8'h00, 1'b0, 1'b0);     // zero length, bad check
        rx_frame(8'h01, 8'h01, 1'b1, 1'b0);     // corrupted checksum
        send_rx(SYNC_BYTE);
        send_rx(SYNC_BYTE);
        send_timeout();                         // abandoned mid-frame
        send_timeout();                         // timeout while idle

        run_random(70);

        // Register settings, extremes included
        write_regs(8'h00, 8'h00);
        hold_req = 1'b1;
        run_random(70);
        write_regs(8'hFF, 8'hFF);
        run_random(70);
        write_regs(8'($urandom), 8'($urandom));
        run_random(70);
        write_regs(8'h80, WR_OPCODE_RESET);
        run_random(70);

        // Drain
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d items under %0d register settings: %0d tx frames, %0d refused.",
                 useful_items, settings, sb.tx_frames, sb.refused);
        $display("Rx: %0d frames closed (%0d bad checksum), %0d timeouts; %0d results checked.",
                 sb.rx_frames, sb.rx_bad, sb.timeouts, sb.checked);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
